// File: design/gmc_pkg.sv
package gmc_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  localparam logic [6:0]  SpoolIdle       = 7'd50;
  localparam logic [6:0]  SpoolStanding   = 7'd90;
  localparam logic [6:0]  SpoolWalkBack   = 7'd20;
  localparam logic [6:0]  SpoolWalkFwd    = 7'd80;
  localparam logic [6:0]  SpoolStairUp    = 7'd70;
  localparam logic [6:0]  SpoolStairDown  = 7'd30;
  localparam logic [6:0]  SpoolSitting    = 7'd10;
  localparam logic [6:0]  SpoolCalib      = 7'd50;
  localparam logic [6:0]  SpoolMax        = 7'd100;
  localparam logic [15:0] DwellStep       = 16'd5;
  localparam logic [3:0]  StrikeCap       = 4'd10;
  localparam logic [3:0]  FaultOverRange  = 4'd1;
  localparam logic signed [15:0] StairExitAngle = 16'sd100;

  typedef enum logic [3:0] {
    MODE_BOOT        = 4'd0,
    MODE_IDLE        = 4'd1,
    MODE_STANDING    = 4'd2,
    MODE_WALKING     = 4'd3,
    MODE_STAIR_UP    = 4'd4,
    MODE_STAIR_DOWN  = 4'd5,
    MODE_SITTING     = 4'd6,
    MODE_CALIBRATION = 4'd7,
    MODE_FAULT       = 4'd8
  } mode_t;

  typedef enum logic [1:0] {
    REQ_SAMPLE     = 2'd0,
    REQ_FORCE_MODE = 2'd1,
    REQ_FAULT      = 2'd2
  } req_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_STAND_FORCE  = 3'd0,
    CFG_SIT_FORCE    = 3'd1,
    CFG_SIT_KNEE     = 3'd2,
    CFG_STAIR_KNEE   = 3'd3,
    CFG_HEEL_FORCE   = 3'd4,
    CFG_HEEL_NEEDED  = 3'd5,
    CFG_STAND_DWELL  = 3'd6,
    CFG_FORCE_LIMIT  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [13:0] stand_force_threshold;
    logic [13:0] sit_force_threshold;
    logic [12:0] sit_knee_thr;
    logic [12:0] stair_knee_thr;
    logic [13:0] heel_strike_force;
    logic [3:0]  heel_strikes_needed;
    logic [15:0] stand_dwell_ms;
    logic [14:0] force_range_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] force_sample;
    logic [15:0] knee_pos;
    logic [3:0]  target_mode;
    logic [3:0]  fault_code;
  } item_t;

  typedef struct packed {
    mode_t       mode;
    mode_t       previous_mode;
    logic [3:0]  fault_held;
    logic [6:0]  spool_target;
    logic [15:0] dwell_accum;
    logic [3:0]  heel_strikes;
  } state_t;

  typedef struct packed {
    logic [6:0] spool_position;
    logic       spool_update;
    logic       emergency_stop;
    logic [3:0] mode_now;
    logic [3:0] mode_before;
    logic [3:0] fault_latched;
  } result_t;

endpackage

// File: design/gmc_if.sv
interface gmc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] force_sample;
  logic [15:0] knee_pos;
  logic [3:0]  target_mode;
  logic [3:0]  fault_code;

  modport source (output valid, req_type, force_sample, knee_pos, target_mode,
                  fault_code, input ready);
  modport sink (input valid, req_type, force_sample, knee_pos, target_mode,
                fault_code, output ready);
endinterface

interface gmc_res_if;
  logic       valid;
  logic       ready;
  logic [6:0] spool_position;
  logic       spool_update;
  logic       emergency_stop;
  logic [3:0] mode_now;
  logic [3:0] mode_before;
  logic [3:0] fault_latched;

  modport source (output valid, spool_position, spool_update, emergency_stop,
                  mode_now, mode_before, fault_latched, input ready);
  modport sink (input valid, spool_position, spool_update, emergency_stop,
                mode_now, mode_before, fault_latched, output ready);
endinterface

// File: design/gmc_cfg_regs.sv
module gmc_cfg_regs import gmc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [CfgIndexWidth-1:0] index,
  input  logic [CfgDataWidth-1:0]  wdata,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stand_force_threshold <= 14'd30;
      cfg.sit_force_threshold   <= 14'd10;
      cfg.sit_knee_thr          <= 13'd800;
      cfg.stair_knee_thr        <= 13'd600;
      cfg.heel_strike_force     <= 14'd200;
      cfg.heel_strikes_needed   <= 4'd3;
      cfg.stand_dwell_ms        <= 16'd200;
      cfg.force_range_limit     <= 15'd5000;
    end else if (we) begin
      case (cfg_idx_t'(index))
        CFG_STAND_FORCE: cfg.stand_force_threshold <= wdata[13:0];
        CFG_SIT_FORCE:   cfg.sit_force_threshold   <= wdata[13:0];
        CFG_SIT_KNEE:    cfg.sit_knee_thr          <= wdata[12:0];
        CFG_STAIR_KNEE:  cfg.stair_knee_thr        <= wdata[12:0];
        CFG_HEEL_FORCE:  cfg.heel_strike_force     <= wdata[13:0];
        CFG_HEEL_NEEDED: cfg.heel_strikes_needed   <= wdata[3:0];
        CFG_STAND_DWELL: cfg.stand_dwell_ms        <= wdata[15:0];
        CFG_FORCE_LIMIT: cfg.force_range_limit     <= wdata[14:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/gmc_step.sv
module gmc_step import gmc_pkg::*; (
  input  item_t   item,
  input  state_t  st,
  input  cfg_t    cfg,
  output state_t  st_next,
  output result_t res
);

  always_comb begin
    logic signed [16:0] f17;
    logic signed [16:0] lim17;
    logic signed [15:0] knee;
    logic               over;
    logic [16:0]        dwell_sum;
    logic [15:0]        dwell_new;
    logic               sit;
    logic [3:0]         hs0;
    logic [3:0]         hs1;
    logic               strike;
    logic               upd;
    logic               estop;

    f17       = $signed({item.force_sample[15], item.force_sample});
    lim17     = $signed({2'b00, cfg.force_range_limit});
    knee      = $signed(item.knee_pos);
    over      = (f17 > lim17) || (f17 < -lim17);
    dwell_sum = {1'b0, st.dwell_accum} + {1'b0, DwellStep};
    dwell_new = dwell_sum[16] ? 16'hFFFF : dwell_sum[15:0];
    sit       = (knee > $signed(cfg.sit_knee_thr)) &&
                ($signed(item.force_sample) < $signed(cfg.sit_force_threshold));
    hs0       = sit ? 4'd0 : st.heel_strikes;
    strike    = ($signed(item.force_sample) > $signed(cfg.heel_strike_force)) &&
                (hs0 < StrikeCap);
    hs1       = strike ? hs0 + 4'd1 : hs0;
    upd       = 1'b0;
    estop     = 1'b0;
    st_next   = st;

    case (req_t'(item.req_type))
      REQ_SAMPLE: begin
        if (st.mode == MODE_FAULT) begin
          upd = 1'b0;
        end else if (over) begin
          estop                 = 1'b1;
          st_next.fault_held    = FaultOverRange;
          st_next.previous_mode = st.mode;
          st_next.mode          = MODE_FAULT;
          st_next.heel_strikes  = 4'd0;
        end else begin
          upd = 1'b1;
          case (st.mode)
            MODE_IDLE: begin
              st_next.spool_target = SpoolIdle;
              if ($signed(item.force_sample) > $signed(cfg.stand_force_threshold)) begin
                st_next.dwell_accum = dwell_new;
                if (dwell_new > cfg.stand_dwell_ms) begin
                  st_next.previous_mode = st.mode;
                  st_next.mode          = MODE_STANDING;
                  st_next.heel_strikes  = 4'd0;
                end
              end else begin
                st_next.dwell_accum = 16'd0;
              end
            end
            MODE_STANDING: begin
              st_next.spool_target = SpoolStanding;
              st_next.heel_strikes = hs1;
              if (sit) begin
                st_next.previous_mode = MODE_STANDING;
                st_next.mode          = MODE_SITTING;
              end
              if (strike && (hs1 >= cfg.heel_strikes_needed)) begin
                st_next.previous_mode = sit ? MODE_SITTING : MODE_STANDING;
                st_next.mode          = MODE_WALKING;
                st_next.heel_strikes  = 4'd0;
              end
            end
            MODE_WALKING: begin
              st_next.spool_target = knee[15] ? SpoolWalkBack : SpoolWalkFwd;
              if (knee > $signed(cfg.stair_knee_thr)) begin
                st_next.previous_mode = st.mode;
                st_next.mode          = MODE_STAIR_DOWN;
                st_next.heel_strikes  = 4'd0;
              end
            end
            MODE_STAIR_UP: begin
              st_next.spool_target = SpoolStairUp;
            end
            MODE_STAIR_DOWN: begin
              st_next.spool_target = SpoolStairDown;
              if (knee < StairExitAngle) begin
                st_next.previous_mode = st.mode;
                st_next.mode          = MODE_STANDING;
                st_next.heel_strikes  = 4'd0;
              end
            end
            MODE_SITTING: begin
              st_next.spool_target = SpoolSitting;
            end
            MODE_CALIBRATION: begin
              st_next.spool_target = SpoolCalib;
            end
            default: begin
            end
          endcase
        end
      end
      REQ_FORCE_MODE: begin
        if (item.target_mode <= MODE_FAULT) begin
          st_next.previous_mode = st.mode;
          st_next.mode          = mode_t'(item.target_mode);
          st_next.heel_strikes  = 4'd0;
        end
      end
      REQ_FAULT: begin
        estop                 = 1'b1;
        st_next.fault_held    = item.fault_code;
        st_next.previous_mode = st.mode;
        st_next.mode          = MODE_FAULT;
        st_next.heel_strikes  = 4'd0;
      end
      default: begin
      end
    endcase

    res.spool_position = st_next.spool_target;
    res.spool_update   = upd;
    res.emergency_stop = estop;
    res.mode_now       = st_next.mode;
    res.mode_before    = st_next.previous_mode;
    res.fault_latched  = st_next.fault_held;
  end

endmodule

// File: design/gait_mode_controller.sv
// channel   dir  handshake      payload
// req       in   valid/ready    req_type force_sample knee_pos target_mode fault_code
// res       out  valid/ready    spool_position spool_update emergency_stop mode_now
//                               mode_before fault_latched
// cfg       in   cfg_we only    cfg_index cfg_wdata
//
// one beat per clock while res.ready is high; a request beat is taken into the input
// register, then its result is held in the result register until res.ready; the mode
// logic is a single pass of threshold compares between the two
// synchronous active-high reset: mode idle, previous mode boot, spool 50
// a stalled result holds in its register while the next beat waits in the input
// register; req.ready drops only when both are full and res.ready is low
module gait_mode_controller import gmc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_wdata,
  gmc_req_if.sink                  req,
  gmc_res_if.source                res
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  state_t  st;
  state_t  st_next;
  result_t step_res;
  result_t out_res;
  logic    out_valid;
  logic    advance;

  assign advance   = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || advance;

  gmc_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  gmc_step u_step (
    .item    (in_item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.req_type     <= req.req_type;
      in_item.force_sample <= req.force_sample;
      in_item.knee_pos     <= req.knee_pos;
      in_item.target_mode  <= req.target_mode;
      in_item.fault_code   <= req.fault_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode          <= MODE_IDLE;
      st.previous_mode <= MODE_BOOT;
      st.fault_held    <= 4'd0;
      st.spool_target  <= SpoolIdle;
      st.dwell_accum   <= 16'd0;
      st.heel_strikes  <= 4'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign res.valid          = out_valid;
  assign res.spool_position = out_res.spool_position;
  assign res.spool_update   = out_res.spool_update;
  assign res.emergency_stop = out_res.emergency_stop;
  assign res.mode_now       = out_res.mode_now;
  assign res.mode_before    = out_res.mode_before;
  assign res.fault_latched  = out_res.fault_latched;

`ifndef ASSERT_OFF
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("mode state changed without a beat");

  a_strike_cap: assert property (@(posedge clk) disable iff (rst)
    st.heel_strikes <= StrikeCap)
    else $error("heel strike count above cap");

  a_spool_range: assert property (@(posedge clk) disable iff (rst)
    st.spool_target <= SpoolMax)
    else $error("spool target out of range");

  a_estop_fault: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.emergency_stop |-> !res.spool_update && res.mode_now == MODE_FAULT)
    else $error("emergency stop without fault mode");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_res.mode_now == st.mode && out_res.spool_position == st.spool_target)
    else $error("result does not reflect updated state");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

import gmc_pkg::*;

class gait_mode_scoreboard;
  cfg_t        regs;
  mode_t       mode;
  mode_t       prev_mode;
  logic [3:0]  fault;
  logic [6:0]  spool;
  logic [15:0] dwell;
  logic [3:0]  strikes;
  result_t     expected_reports[$];
  int          requests;
  int          reports;
  int          mismatches;
  int          estops;
  logic [8:0]  modes_seen;

  function new();
    regs.stand_force_threshold = 14'd30;
    regs.sit_force_threshold   = 14'd10;
    regs.sit_knee_thr          = 13'd800;
    regs.stair_knee_thr        = 13'd600;
    regs.heel_strike_force     = 14'd200;
    regs.heel_strikes_needed   = 4'd3;
    regs.stand_dwell_ms        = 16'd200;
    regs.force_range_limit     = 15'd5000;
    mode       = MODE_IDLE;
    prev_mode  = MODE_BOOT;
    fault      = '0;
    spool      = SpoolIdle;
    dwell      = '0;
    strikes    = '0;
    modes_seen = '0;
    modes_seen[MODE_IDLE] = 1'b1;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [15:0] d);
    case (idx)
      CFG_STAND_FORCE: regs.stand_force_threshold = d[13:0];
      CFG_SIT_FORCE:   regs.sit_force_threshold   = d[13:0];
      CFG_SIT_KNEE:    regs.sit_knee_thr          = d[12:0];
      CFG_STAIR_KNEE:  regs.stair_knee_thr        = d[12:0];
      CFG_HEEL_FORCE:  regs.heel_strike_force     = d[13:0];
      CFG_HEEL_NEEDED: regs.heel_strikes_needed   = d[3:0];
      CFG_STAND_DWELL: regs.stand_dwell_ms        = d[15:0];
      CFG_FORCE_LIMIT: regs.force_range_limit     = d[14:0];
      default: ;
    endcase
  endfunction

  function void enter(mode_t m);
    prev_mode = mode;
    mode = m;
    strikes = '0;
    modes_seen[m] = 1'b1;
  endfunction

  function void note_request(item_t it);
    result_t r;
    int f;
    int k;
    int lim;
    bit upd;
    bit stop;
    f = $signed(it.force_sample);
    k = $signed(it.knee_pos);
    lim = regs.force_range_limit;
    upd = 1'b0;
    stop = 1'b0;
    requests++;
    case (it.req_type)
      REQ_SAMPLE: begin
        if (mode != MODE_FAULT) begin
          if (f > lim || f < -lim) begin
            fault = FaultOverRange;
            enter(MODE_FAULT);
            stop = 1'b1;
          end else begin
            upd = 1'b1;
            case (mode)
              MODE_IDLE: begin
                spool = SpoolIdle;
                if (f > $signed(regs.stand_force_threshold)) begin
                  dwell = (dwell > 16'hFFFF - DwellStep) ? 16'hFFFF : dwell + DwellStep;
                  if (dwell > regs.stand_dwell_ms) enter(MODE_STANDING);
                end else begin
                  dwell = '0;
                end
              end
              MODE_STANDING: begin
                spool = SpoolStanding;
                // sitting is checked first, strikes still count in the same sample
                if (k > $signed(regs.sit_knee_thr) && f < $signed(regs.sit_force_threshold))
                  enter(MODE_SITTING);
                if (f > $signed(regs.heel_strike_force) && strikes < StrikeCap) begin
                  strikes++;
                  if (strikes >= regs.heel_strikes_needed) enter(MODE_WALKING);
                end
              end
              MODE_WALKING: begin
                spool = (k < 0) ? SpoolWalkBack : SpoolWalkFwd;
                if (k > $signed(regs.stair_knee_thr)) enter(MODE_STAIR_DOWN);
              end
              MODE_STAIR_UP: spool = SpoolStairUp;
              MODE_STAIR_DOWN: begin
                spool = SpoolStairDown;
                if (k < StairExitAngle) enter(MODE_STANDING);
              end
              MODE_SITTING:     spool = SpoolSitting;
              MODE_CALIBRATION: spool = SpoolCalib;
              default: ;
            endcase
          end
        end
      end
      REQ_FORCE_MODE: begin
        if (it.target_mode <= MODE_FAULT) enter(mode_t'(it.target_mode));
      end
      REQ_FAULT: begin
        fault = it.fault_code;
        enter(MODE_FAULT);
        stop = 1'b1;
      end
      default: ;
    endcase
    if (stop) estops++;
    r.spool_position = spool;
    r.spool_update   = upd;
    r.emergency_stop = stop;
    r.mode_now       = mode;
    r.mode_before    = prev_mode;
    r.fault_latched  = fault;
    expected_reports.push_back(r);
  endfunction

  function void check_report(result_t got);
    result_t want;
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("report with nothing expected: spool %0d upd %b stop %b mode %0d/%0d fault %0d",
                 got.spool_position, got.spool_update, got.emergency_stop, got.mode_now,
                 got.mode_before, got.fault_latched);
      return;
    end
    want = expected_reports.pop_front();
    reports++;
    if (got.spool_position !== want.spool_position || got.spool_update !== want.spool_update ||
        got.emergency_stop !== want.emergency_stop || got.mode_now !== want.mode_now ||
        got.mode_before !== want.mode_before || got.fault_latched !== want.fault_latched) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"report %0d (expected/actual): spool %0d/%0d upd %b/%b stop %b/%b ",
                  "mode %0d/%0d before %0d/%0d fault %0d/%0d"},
                 reports, want.spool_position, got.spool_position, want.spool_update,
                 got.spool_update, want.emergency_stop, got.emergency_stop, want.mode_now,
                 got.mode_now, want.mode_before, got.mode_before, want.fault_latched,
                 got.fault_latched);
    end
  endfunction
endclass

module testbench;
  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam int CycleLimit    = 1_500_000;
  localparam int PhaseItems    = 250;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_wdata;

  gmc_req_if req_ch();
  gmc_res_if res_ch();

  gait_mode_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  gait_mode_scoreboard board = new();
  bit steady_src;
  bit steady_sink;
  int cycles;

  int directed_cfg[8] = '{30, 10, 800, 600, 200, 3, 10, 5000};
  int reset_cfg[8]    = '{30, 10, 800, 600, 200, 3, 200, 5000};
  int low_cfg[8]      = '{-5000, -5000, -3600, -3600, -5000, 0, 0, 0};
  int high_cfg[8]     = '{5000, 5000, 3600, 3600, 5000, 10, 65535, 32767};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // mostly short gaps, a few long
  function automatic int gap_len();
    int r;
    r = span(0, 99);
    if (r < 55) return 0;
    if (r < 85) return span(1, 3);
    if (r < 97) return span(4, 12);
    return span(20, 50);
  endfunction

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic item_t make_item(logic [1:0] rq, int f, int k, logic [3:0] tm,
                                      logic [3:0] fc);
    item_t it;
    it.req_type     = rq;
    it.force_sample = clamp16(f);
    it.knee_pos     = clamp16(k);
    it.target_mode  = tm;
    it.fault_code   = fc;
    return it;
  endfunction

  function automatic item_t random_item();
    int pick;
    int f;
    int k;
    int lim;
    int stand_thr;
    int sit_thr;
    int heel_thr;
    logic [1:0] rq;
    logic [3:0] tm;
    lim       = board.regs.force_range_limit;
    stand_thr = $signed(board.regs.stand_force_threshold);
    sit_thr   = $signed(board.regs.sit_force_threshold);
    heel_thr  = $signed(board.regs.heel_strike_force);
    pick = span(0, 99);
    if (board.mode == MODE_FAULT && pick < 50) rq = REQ_FORCE_MODE;
    else if (pick < 82) rq = REQ_SAMPLE;
    else if (pick < 91) rq = REQ_FORCE_MODE;
    else if (pick < 96) rq = REQ_FAULT;
    else rq = REQ_RESERVED;
    tm = (span(0, 9) < 8) ? 4'(span(MODE_BOOT, MODE_FAULT)) : 4'(span(9, 15));
    pick = span(0, 9);
    if (pick == 0) f = span(-32768, 32767);
    else if (pick == 1) f = (span(0, 1) ? lim : -lim) + span(-1, 1);
    else begin
      case (board.mode)
        MODE_IDLE: f = (pick < 8) ? stand_thr + span(1, 300) : stand_thr - span(0, 300);
        MODE_STANDING: begin
          case (pick % 3)
            0: f = heel_thr + span(1, 200);
            1: f = sit_thr - span(1, 200);
            default: f = heel_thr + span(-300, 300);
          endcase
        end
        default: f = span(-1500, 1500);
      endcase
    end
    pick = span(0, 9);
    if (pick == 0) k = span(-32768, 32767);
    else if (pick < 4) k = $signed(board.regs.sit_knee_thr) + span(-40, 40);
    else if (pick < 7) k = $signed(board.regs.stair_knee_thr) + span(-40, 40);
    else if (pick < 8) k = int'(StairExitAngle) + span(-40, 40);
    else k = span(-40, 40);
    return make_item(rq, f, k, tm, 4'($urandom));
  endfunction

  task automatic send(item_t it);
    int gap;
    gap = steady_src ? 0 : gap_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= it.req_type;
    req_ch.force_sample <= it.force_sample;
    req_ch.knee_pos     <= it.knee_pos;
    req_ch.target_mode  <= it.target_mode;
    req_ch.fault_code   <= it.fault_code;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_request(it);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(input int vals[8]);
    cfg_idx_t idx;
    idx = CFG_STAND_FORCE;
    do begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= vals[idx][15:0];
      @(posedge clk);
      board.write_reg(idx, vals[idx][15:0]);
      idx = idx.next();
    end while (idx != CFG_STAND_FORCE);
    cfg_we <= 1'b0;
  endtask

  // result side: random back-pressure, checks each accepted beat
  initial begin
    int hold;
    result_t got;
    hold = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got.spool_position = res_ch.spool_position;
        got.spool_update   = res_ch.spool_update;
        got.emergency_stop = res_ch.emergency_stop;
        got.mode_now       = res_ch.mode_now;
        got.mode_before    = res_ch.mode_before;
        got.fault_latched  = res_ch.fault_latched;
        board.check_report(got);
      end
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (!steady_sink && span(0, 3) == 0) hold = gap_len();
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("no progress after %0d cycles, %0d reports outstanding", cycles,
             board.expected_reports.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int vals[8];
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_wdata           <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= '0;
    req_ch.force_sample <= '0;
    req_ch.knee_pos     <= '0;
    req_ch.target_mode  <= '0;
    req_ch.fault_code   <= '0;
    steady_src  = 1'b0;
    steady_sink = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the mode graph with a short dwell
    write_settings(directed_cfg);
    send(make_item(REQ_RESERVED, 0, 0, MODE_STANDING, 4'd5));
    send(make_item(REQ_SAMPLE, 0, 0, MODE_BOOT, 4'd0));
    repeat (3) send(make_item(REQ_SAMPLE, 100, 0, MODE_BOOT, 4'd0));
    send(make_item(REQ_SAMPLE, 0, 900, MODE_BOOT, 4'd0));
    send(make_item(REQ_SAMPLE, 0, 0, MODE_BOOT, 4'd0));
    send(make_item(REQ_FORCE_MODE, 0, 0, MODE_STANDING, 4'd0));
    repeat (3) send(make_item(REQ_SAMPLE, 300, -5, MODE_BOOT, 4'd0));
    send(make_item(REQ_SAMPLE, 100, -50, MODE_BOOT, 4'd0));
    send(make_item(REQ_SAMPLE, 100, 700, MODE_BOOT, 4'd0));
    send(make_item(REQ_SAMPLE, 0, 50, MODE_BOOT, 4'd0));
    send(make_item(REQ_FORCE_MODE, 0, 0, MODE_STAIR_UP, 4'd0));
    send(make_item(REQ_SAMPLE, 0, 0, MODE_BOOT, 4'd0));
    send(make_item(REQ_FORCE_MODE, 0, 0, MODE_CALIBRATION, 4'd0));
    send(make_item(REQ_SAMPLE, 0, 0, MODE_BOOT, 4'd0));
    send(make_item(REQ_FORCE_MODE, 0, 0, MODE_BOOT, 4'd0));
    send(make_item(REQ_SAMPLE, 0, 0, MODE_BOOT, 4'd0));
    send(make_item(REQ_FORCE_MODE, 0, 0, 4'd9, 4'd0));
    send(make_item(REQ_FORCE_MODE, 0, 0, 4'd15, 4'd0));
    send(make_item(REQ_SAMPLE, 32767, 0, MODE_BOOT, 4'd0));
    send(make_item(REQ_SAMPLE, 0, 0, MODE_BOOT, 4'd0));
    send(make_item(REQ_FAULT, 0, 0, MODE_BOOT, 4'd15));
    send(make_item(REQ_FORCE_MODE, 0, 0, MODE_IDLE, 4'd0));
    send(make_item(REQ_SAMPLE, -32768, -32768, MODE_BOOT, 4'd0));
    send(make_item(REQ_FORCE_MODE, 0, 0, MODE_IDLE, 4'd0));
    send(make_item(REQ_SAMPLE, 5000, 32767, MODE_BOOT, 4'd0));
    send(make_item(REQ_SAMPLE, -5000, -32768, MODE_BOOT, 4'd0));
    send(make_item(REQ_FAULT, 0, 0, MODE_BOOT, 4'd0));
    send(make_item(REQ_FORCE_MODE, 0, 0, MODE_SITTING, 4'd0));
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: vals = reset_cfg;
        1: vals = low_cfg;
        2: vals = high_cfg;
        3: begin
          foreach (vals[i]) vals[i] = span(0, 65535);
          vals[CFG_HEEL_NEEDED] = 16'hFFFF;
        end
        default: vals = '{span(-5000, 5000), span(-5000, 5000), span(-3600, 3600),
                          span(-3600, 3600), span(-5000, 5000), span(0, 10), span(0, 400),
                          span(0, 32767)};
      endcase
      write_settings(vals);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 50 == 0) begin
          steady_src  = (span(0, 4) == 0);
          steady_sink = (span(0, 4) == 0);
        end
        send(random_item());
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("%0d requests sent, %0d reports checked, %0d emergency stops, %0d mismatches",
             board.requests, board.reports, board.estops, board.mismatches);
    $display("modes entered %b across nine register settings with random stalls",
             board.modes_seen);
    if (board.mismatches == 0 && board.expected_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: files.f
design/gmc_pkg.sv
design/gmc_if.sv
design/gmc_cfg_regs.sv
design/gmc_step.sv
design/gait_mode_controller.sv
test/testbench.sv
